// ===== rtl/rmf_pkg.sv =====
package rmf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_KERNEL_DEF = 7;
    localparam int PIX_W          = 24;
    localparam int CH_W           = 8;

    // register indexes of the configuration port
    localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    // control of the sorting chain, shared by all cells
    typedef struct packed {
        logic clear;
        logic insert;
    } chain_ctrl_t;

endpackage

// ===== rtl/rmf_sort_cell.sv =====
module rmf_sort_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rmf_pkg::chain_ctrl_t      ctrl,
    input  logic [rmf_pkg::PIX_W-1:0] new_pix,
    input  logic [rmf_pkg::PIX_W-1:0] left_pix,
    input  logic [2:0]                left_gt,
    input  logic                      left_valid,
    output logic [rmf_pkg::PIX_W-1:0] pix,
    output logic [2:0]                gt,
    output logic                      valid
);
    import rmf_pkg::*;

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;
    logic             valid_reg;

    // per channel: does this cell move right on insert
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            gt[c] = !valid_reg || (pix_reg[c*CH_W +: CH_W] > new_pix[c*CH_W +: CH_W]);
        end
    end

    // take left value if left shifts too, else the new value
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (gt[c]) begin
                pix_next[c*CH_W +: CH_W] = left_gt[c] ? left_pix[c*CH_W +: CH_W]
                                                      : new_pix[c*CH_W +: CH_W];
            end else begin
                pix_next[c*CH_W +: CH_W] = pix_reg[c*CH_W +: CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.insert) begin
            valid_reg <= valid_reg | left_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert) begin
            pix_reg <= pix_next;
        end
    end

    assign pix   = pix_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/rmf_sort_chain.sv =====
module rmf_sort_chain #(
    parameter int NUM_CELLS = 49
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rmf_pkg::chain_ctrl_t                ctrl,
    input  logic [rmf_pkg::PIX_W-1:0]           new_pix,
    output logic [NUM_CELLS*rmf_pkg::PIX_W-1:0] sorted_pix
);
    import rmf_pkg::*;

    logic [PIX_W-1:0] pix   [NUM_CELLS];
    logic [2:0]       gt    [NUM_CELLS];
    logic             valid [NUM_CELLS];

    // row of cells, ascending from cell 0
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic [PIX_W-1:0] lp;
        logic [2:0]       lg;
        logic             lv;
        if (i == 0) begin : g_head
            // nothing shifts in from the left, the head takes the new value
            assign lp = '0;
            assign lg = 3'b000;
            assign lv = 1'b1;
        end else begin : g_body
            assign lp = pix[i-1];
            assign lg = gt[i-1];
            assign lv = valid[i-1];
        end
        rmf_sort_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_pix    (new_pix),
            .left_pix   (lp),
            .left_gt    (lg),
            .left_valid (lv),
            .pix        (pix[i]),
            .gt         (gt[i]),
            .valid      (valid[i])
        );
        assign sorted_pix[i*PIX_W +: PIX_W] = pix[i];
    end

endmodule

// ===== rtl/rmf_line_store.sv =====
module rmf_line_store #(
    parameter int DEPTH = 7168,
    parameter int AW    = 13
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [rmf_pkg::PIX_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [rmf_pkg::PIX_W-1:0] rd_data
);
    import rmf_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rgb_median_filter_core.sv =====
// channel   dir  ports                       contents
// s_        in   tvalid tready tdata tuser   pixel, frame start flag
// m_        out  tvalid tready tdata tlast   median pixel, position, last of run
// cfg_      in   wr_en index wdata           kernel size, frame width, frame height
//
// one input word per cycle when it releases nothing; for each released result
// the window is read one pixel a cycle from the single line store read port and
// inserted into the sorting chain, then the median is taken
// reset is synchronous, active low; the line store is not cleared
// input is held off while the results of a pixel are produced; a stalled output
// holds the sequencer in its wait step
module rgb_median_filter_core #(
    parameter int MAX_WIDTH  = rmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]  s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red_out, green_out, blue_out, out_column, out_row
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import rmf_pkg::*;

    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int NCELL  = MAX_KERNEL * MAX_KERNEL;
    localparam int MW     = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int KLIM   = (MAX_KERNEL - 1) | 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      ks_reg;
    logic [10:0]     fw_reg;
    logic [15:0]     fh_reg;
    logic [XW-1:0]   col_reg;
    logic [15:0]     row_reg;
    logic [SW-1:0]   slot_reg;
    logic [XW-1:0]   jx_reg, x0_reg, x1_reg;
    logic [15:0]     jy_reg, y1_reg, cy_reg;
    logic [SW-1:0]   cslot_reg;
    logic [KW-1:0]   kx_reg, ky_reg;
    logic            rdv_reg;
    logic            mv_reg;
    logic [55:0]     md_reg;
    logic            ml_reg;

    // effective settings
    int          k_i, hk_i, w_i, h_i;
    logic [KW-1:0] k_m1;
    logic [MW-1:0] mid;
    always_comb begin
        int kraw, kk;
        kraw = int'(ks_reg) | 1;
        k_i  = (kraw > KLIM) ? KLIM : kraw;
        hk_i = k_i >> 1;
        kk   = k_i * k_i;
        mid  = MW'(kk >> 1);
        k_m1 = KW'(k_i - 1);
        w_i  = (fw_reg == 11'd0) ? 1 : ((int'(fw_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(fw_reg));
        h_i  = (fh_reg == 16'd0) ? 1 : int'(fh_reg);
    end

    // position of the arriving pixel and the range of results it releases
    logic            accept;
    logic [XW-1:0]   cx, col_next;
    logic [15:0]     cy, row_next;
    logic [SW-1:0]   cs, slot_next;
    logic            has_res;
    int              x0_i, x1_i, y0_i, y1_i;
    always_comb begin
        logic rst_pos, hasx, hasy;
        rst_pos = s_tuser[0] || (int'(col_reg) >= w_i) || (int'(row_reg) >= h_i);
        cx = rst_pos ? '0 : col_reg;
        cy = rst_pos ? '0 : row_reg;
        cs = rst_pos ? '0 : slot_reg;
        x0_i = 0; x1_i = 0; y0_i = 0; y1_i = 0;
        hasx = 1'b1;
        hasy = 1'b1;
        if (int'(cx) == w_i - 1) begin
            x0_i = (w_i - 1 >= hk_i) ? (w_i - 1 - hk_i) : 0;
            x1_i = w_i - 1;
        end else if (int'(cx) >= hk_i) begin
            x0_i = int'(cx) - hk_i;
            x1_i = x0_i;
        end else begin
            hasx = 1'b0;
        end
        if (int'(cy) == h_i - 1) begin
            y0_i = (h_i - 1 >= hk_i) ? (h_i - 1 - hk_i) : 0;
            y1_i = h_i - 1;
        end else if (int'(cy) >= hk_i) begin
            y0_i = int'(cy) - hk_i;
            y1_i = y0_i;
        end else begin
            hasy = 1'b0;
        end
        has_res = hasx && hasy;
        col_next = col_reg;
        row_next = row_reg;
        slot_next = slot_reg;
        if (int'(cx) + 1 >= w_i) begin
            col_next = '0;
            if (int'(cy) + 1 >= h_i) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = cy + 16'd1;
                slot_next = (int'(cs) == MAX_KERNEL - 1) ? '0 : SW'(int'(cs) + 1);
            end
        end else begin
            col_next = XW'(int'(cx) + 1);
            row_next = cy;
            slot_next = cs;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // window read address, clamped to the frame
    logic [AW-1:0] rd_addr, wr_addr;
    always_comb begin
        int px, py, d, sl;
        px = int'(jx_reg) + int'(kx_reg) - hk_i;
        if (px < 0) px = 0;
        if (px > w_i - 1) px = w_i - 1;
        py = int'(jy_reg) + int'(ky_reg) - hk_i;
        if (py < 0) py = 0;
        if (py > h_i - 1) py = h_i - 1;
        d  = int'(cy_reg) - py;
        sl = (int'(cslot_reg) >= d) ? (int'(cslot_reg) - d) : (int'(cslot_reg) + MAX_KERNEL - d);
        rd_addr = AW'(sl * MAX_WIDTH + px);
        wr_addr = AW'(int'(cs) * MAX_WIDTH + int'(cx));
    end

    logic             rd_en;
    logic [PIX_W-1:0] rd_data;
    assign rd_en = (state_reg == ST_RUN);

    rmf_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sorting chain
    chain_ctrl_t              cctrl;
    logic [NCELL*PIX_W-1:0]   sorted;
    logic [PIX_W-1:0]         med;
    logic                     out_free, is_last, start_run;

    assign out_free  = !mv_reg || m_tready;
    assign is_last   = (jx_reg == x1_reg) && (jy_reg == y1_reg);
    assign start_run = (accept && has_res) || ((state_reg == ST_WAIT) && out_free && !is_last);
    assign cctrl.clear  = start_run;
    assign cctrl.insert = rdv_reg;
    assign med = sorted[int'(mid)*PIX_W +: PIX_W];

    rmf_sort_chain #(
        .NUM_CELLS (NCELL)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cctrl),
        .new_pix    (rd_data),
        .sorted_pix (sorted)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && has_res) state_next = ST_RUN;
            ST_RUN:   if (kx_reg == k_m1 && ky_reg == k_m1) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_WAIT;
            ST_WAIT:  if (out_free) state_next = is_last ? ST_IDLE : ST_RUN;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ks_reg    <= 3'd3;
            fw_reg    <= 11'd1024;
            fh_reg    <= 16'd1024;
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            rdv_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rdv_reg   <= rd_en;
            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_KERNEL_SIZE:  ks_reg <= cfg_wdata[2:0];
                    REG_FRAME_WIDTH:  fw_reg <= cfg_wdata[10:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            // output word
            if (state_reg == ST_WAIT && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // job and window counters
    always_ff @(posedge aclk) begin
        if (accept) begin
            jx_reg    <= XW'(x0_i);
            jy_reg    <= 16'(y0_i);
            x0_reg    <= XW'(x0_i);
            x1_reg    <= XW'(x1_i);
            y1_reg    <= 16'(y1_i);
            cy_reg    <= cy;
            cslot_reg <= cs;
        end else if (state_reg == ST_WAIT && out_free && !is_last) begin
            if (jx_reg == x1_reg) begin
                jx_reg <= x0_reg;
                jy_reg <= jy_reg + 16'd1;
            end else begin
                jx_reg <= jx_reg + XW'(1);
            end
        end
        if (start_run) begin
            kx_reg <= '0;
            ky_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            if (kx_reg == k_m1) begin
                kx_reg <= '0;
                ky_reg <= ky_reg + KW'(1);
            end else begin
                kx_reg <= kx_reg + KW'(1);
            end
        end
        if (state_reg == ST_WAIT && out_free) begin
            md_reg <= {6'd0, jy_reg, 10'(32'(jx_reg)), med};
            ml_reg <= is_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

// ===== rtl/rmf_checker.sv =====
module rmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // output empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // stalled output word stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output word changed");

    // padding bits of the output word are zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:50] == 6'd0)
        else $error("output padding not zero");

    // accepting a pixel and completing a result never overlap with a new result
    a_no_burst_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid) && !$past(m_tready)))
        else $error("result appeared in the cycle after an input accept");

endmodule

bind rgb_median_filter_core rmf_checker u_rmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
